[sv/sst_pkg.sv]
package sst_pkg;

    localparam int DEPTH      = 8;
    localparam int VALUE_BITS = 16;
    localparam int POS_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef enum logic [1:0] {
        CMD_NONE   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_ROTATE = 2'd3
    } cell_cmd_t;

    typedef enum logic [1:0] {
        ACT_LOADED   = 2'd0,
        ACT_DELETED  = 2'd1,
        ACT_INSERTED = 2'd2,
        ACT_REJECTED = 2'd3
    } action_t;

    typedef enum logic {
        KIND_LOAD   = 1'b0,
        KIND_TOGGLE = 1'b1
    } kind_t;

    // view of one cell as its neighbors see it
    typedef struct packed {
        value_t entry;
        logic   valid;
        logic   gt;     // empty, or holds a value above the key
    } nbr_t;

endpackage

[sv/sst_cell.sv]
module sst_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  sst_pkg::cell_cmd_t cmd,
    input  sst_pkg::value_t    key,
    input  sst_pkg::nbr_t      prev,
    input  sst_pkg::nbr_t      next,
    input  sst_pkg::value_t    wrap_entry,
    output sst_pkg::nbr_t      here,
    output logic               match
);
    import sst_pkg::*;

    value_t entry_reg, entry_next;
    logic   valid_reg, valid_next;

    assign here.entry = entry_reg;
    assign here.valid = valid_reg;
    assign here.gt    = !valid_reg || (entry_reg > key);
    assign match      = valid_reg && (entry_reg == key);

    always_comb begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (cmd)
            CMD_NONE: begin
            end
            CMD_INSERT: begin
                if (here.gt) begin
                    if (!prev.gt) begin
                        entry_next = key;
                        valid_next = 1'b1;
                    end else begin
                        entry_next = prev.entry;
                        valid_next = prev.valid;
                    end
                end
            end
            CMD_DELETE: begin
                if (valid_reg && entry_reg >= key) begin
                    entry_next = next.entry;
                    valid_next = next.valid;
                end
            end
            CMD_ROTATE: begin
                if (valid_reg) begin
                    entry_next = next.valid ? next.entry : wrap_entry;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

endmodule

[sv/sorted_set_toggle_table_core.sv]
// Sorted table of signed values held in a chain of cells, one entry per cell.
// A load without s_load_last emits nothing; a toggle or a last load is registered
// and its first result shows the next cycle. s_ready stays low until all results are
// taken, one rotation per result, as the cell chain rotates the table out through cell 0.
// Reset: synchronous, active low; clears the count and all cell valid bits.
module sorted_set_toggle_table_core (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_kind,
    input  logic signed [sst_pkg::VALUE_BITS-1:0] s_value,
    input  logic                                 s_load_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [sst_pkg::VALUE_BITS-1:0] m_entry_value,
    output logic [2:0]                           m_entry_position,
    output logic                                 m_last_entry,
    output logic [1:0]                           m_action,
    output logic [3:0]                           m_entry_count,
    output logic                                 m_table_empty
);
    import sst_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                 state_reg;
    logic [POS_W-1:0]       pos_reg;
    action_t                action_reg;
    logic [CNT_W-1:0]       count_reg;

    cell_cmd_t              cmd;
    nbr_t                   cells [DEPTH];
    logic [DEPTH-1:0]       match_vec;
    logic [DEPTH-1:0]       valid_vec;
    logic                   found;
    logic                   full;
    logic                   in_xfer;
    logic                   out_xfer;

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = (state_reg == ST_EMIT);
    assign in_xfer  = s_valid && s_ready;
    assign out_xfer = m_valid && m_ready;
    assign found    = |match_vec;
    assign full     = valid_vec[DEPTH-1];

    always_comb begin
        cmd = CMD_NONE;
        if (in_xfer) begin
            if (s_kind == KIND_TOGGLE && found) begin
                cmd = CMD_DELETE;
            end else if (!full) begin
                cmd = CMD_INSERT;
            end
        end else if (out_xfer) begin
            cmd = CMD_ROTATE;
        end
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        nbr_t prev_n;
        nbr_t next_n;
        if (i == 0) begin : g_first
            assign prev_n = '{entry: '0, valid: 1'b1, gt: 1'b0};
        end else begin : g_mid
            assign prev_n = cells[i-1];
        end
        if (i == DEPTH - 1) begin : g_end
            assign next_n = '{entry: '0, valid: 1'b0, gt: 1'b1};
        end else begin : g_inner
            assign next_n = cells[i+1];
        end
        assign valid_vec[i] = cells[i].valid;

        sst_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .key        (s_value),
            .prev       (prev_n),
            .next       (next_n),
            .wrap_entry (cells[0].entry),
            .here       (cells[i]),
            .match      (match_vec[i])
        );
    end

    assign m_table_empty    = (count_reg == '0);
    assign m_entry_value    = m_table_empty ? '0 : cells[0].entry;
    assign m_entry_position = 3'(pos_reg);
    assign m_action         = action_reg;
    assign m_entry_count    = 4'(count_reg);
    assign m_last_entry     = m_table_empty || (CNT_W'(pos_reg) == count_reg - 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            pos_reg    <= '0;
            action_reg <= ACT_LOADED;
            count_reg  <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_xfer) begin
                        pos_reg <= '0;
                        if (cmd == CMD_INSERT) begin
                            count_reg <= count_reg + 1'b1;
                        end else if (cmd == CMD_DELETE) begin
                            count_reg <= count_reg - 1'b1;
                        end
                        if (s_kind == KIND_LOAD) begin
                            action_reg <= full ? ACT_REJECTED : ACT_LOADED;
                            if (s_load_last) begin
                                state_reg <= ST_EMIT;
                            end
                        end else begin
                            state_reg <= ST_EMIT;
                            if (found) begin
                                action_reg <= ACT_DELETED;
                            end else begin
                                action_reg <= full ? ACT_REJECTED : ACT_INSERTED;
                            end
                        end
                    end
                end
                ST_EMIT: begin
                    if (out_xfer) begin
                        if (m_last_entry) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(valid_vec) == int'(count_reg))
        else $error("count differs from occupied cells");

    a_cells_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        ((valid_vec + 1'b1) & valid_vec) == '0)
        else $error("occupied cells not contiguous from cell 0");

    a_one_side_open: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input taken during emission");

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_table_empty || CNT_W'(pos_reg) < count_reg))
        else $error("emit position beyond count");

    a_no_change_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && $past(m_valid)) |-> $stable(count_reg))
        else $error("count changed during emission");
`endif

endmodule

[tb/sorted_set_toggle_table_core_tb.sv]
module sorted_set_toggle_table_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sst_pkg::*;

    localparam int STALL_LIMIT = 4000;
    localparam int RAND_ITEMS  = 92;

    typedef struct {
        value_t      value;
        logic [2:0]  pos;
        logic        last;
        action_t     act;
        logic [3:0]  count;
        logic        empty;
    } table_entry_t;

    class sorted_table_scoreboard;
        value_t       tbl[DEPTH];
        int unsigned  cnt;
        table_entry_t expected_entries[$];
        int unsigned  errors;
        int unsigned  items_seen;
        int unsigned  results_seen;
        int unsigned  empty_runs;
        int unsigned  action_runs[4];

        function bit put_sorted(value_t v);
            int unsigned pos;
            if (cnt >= DEPTH) return 1'b0;
            pos = 0;
            while (pos < cnt && tbl[pos] <= v) pos++;
            for (int unsigned k = cnt; k > pos; k--) tbl[k] = tbl[k-1];
            tbl[pos] = v;
            cnt++;
            return 1'b1;
        endfunction

        function void emit_table(action_t act);
            table_entry_t e;
            action_runs[act]++;
            e.act = act;
            if (cnt == 0) begin
                e.value = '0;
                e.pos   = '0;
                e.last  = 1'b1;
                e.count = '0;
                e.empty = 1'b1;
                empty_runs++;
                expected_entries.push_back(e);
                return;
            end
            for (int unsigned k = 0; k < cnt; k++) begin
                e.value = tbl[k];
                e.pos   = 3'(k);
                e.last  = (k + 1 == cnt);
                e.count = 4'(cnt);
                e.empty = 1'b0;
                expected_entries.push_back(e);
            end
        endfunction

        function void note_item(kind_t kind, value_t v, logic last);
            bit          ok;
            int unsigned k;
            items_seen++;
            if (kind == KIND_LOAD) begin
                ok = put_sorted(v);
                if (last) emit_table(ok ? ACT_LOADED : ACT_REJECTED);
                return;
            end
            for (k = 0; k < cnt; k++) begin
                if (tbl[k] == v) begin
                    while (k + 1 < cnt) begin
                        tbl[k] = tbl[k+1];
                        k++;
                    end
                    cnt--;
                    emit_table(ACT_DELETED);
                    return;
                end
            end
            emit_table(put_sorted(v) ? ACT_INSERTED : ACT_REJECTED);
        endfunction

        function void check_entry(value_t v, logic [2:0] pos, logic last,
                                  logic [1:0] act, logic [3:0] count, logic empty);
            table_entry_t e;
            if (expected_entries.size() == 0) begin
                $error("unexpected result transfer: entry_value %0d position %0d", v, pos);
                errors++;
                return;
            end
            e = expected_entries.pop_front();
            results_seen++;
            if (v !== e.value) begin
                $error("entry_value: expected %0d, got %0d", e.value, v);
                errors++;
            end
            if (pos !== e.pos) begin
                $error("entry_position: expected %0d, got %0d", e.pos, pos);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_entry: expected %0d, got %0d", e.last, last);
                errors++;
            end
            if (act !== e.act) begin
                $error("action: expected %0d, got %0d", e.act, act);
                errors++;
            end
            if (count !== e.count) begin
                $error("entry_count: expected %0d, got %0d", e.count, count);
                errors++;
            end
            if (empty !== e.empty) begin
                $error("table_empty: expected %0d, got %0d", e.empty, empty);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_entries.size();
        endfunction
    endclass

    logic         aclk        = 1'b0;
    logic         aresetn     = 1'b0;
    logic         s_valid     = 1'b0;
    logic         s_ready;
    logic         s_kind      = 1'b0;
    value_t       s_value     = '0;
    logic         s_load_last = 1'b0;
    logic         m_valid;
    logic         m_ready     = 1'b0;
    value_t       m_entry_value;
    logic [2:0]   m_entry_position;
    logic         m_last_entry;
    logic [1:0]   m_action;
    logic [3:0]   m_entry_count;
    logic         m_table_empty;

    sorted_table_scoreboard sb;
    int unsigned src_idle_pct   = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned idle_cycles    = 0;

    sorted_set_toggle_table_core u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_value          (s_value),
        .s_load_last      (s_load_last),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entry_value    (m_entry_value),
        .m_entry_position (m_entry_position),
        .m_last_entry     (m_last_entry),
        .m_action         (m_action),
        .m_entry_count    (m_entry_count),
        .m_table_empty    (m_table_empty)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            sb.check_entry(m_entry_value, m_entry_position, m_last_entry,
                           m_action, m_entry_count, m_table_empty);
        end
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_item(input kind_t kind, input value_t value, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_kind      <= kind;
        s_value     <= value;
        s_load_last <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(kind, value, last);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() != 0);
    endtask

    // mostly small values and table members so toggles both hit and miss
    function automatic value_t pick_value();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 30 && sb.cnt > 0) return sb.tbl[$urandom_range(sb.cnt - 1)];
        if (r < 60) return value_t'(int'($urandom_range(8)) - 4);
        if (r < 65) return value_t'(32767);
        if (r < 70) return value_t'(-32768);
        return value_t'($urandom);
    endfunction

    task automatic send_random_item();
        if ($urandom_range(99) < 40) begin
            send_item(KIND_LOAD, pick_value(), $urandom_range(99) < 35);
        end else begin
            send_item(KIND_TOGGLE, pick_value(), 1'($urandom_range(1)));
        end
    endtask

    initial begin
        int unsigned src_mix[4];
        int unsigned sink_mix[4];
        src_mix  = '{0, 86, 0, 27};
        sink_mix = '{0, 0, 86, 27};
        sb = new;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_item(KIND_LOAD, 0, 1'b0);
        send_item(KIND_LOAD, -32768, 1'b0);
        send_item(KIND_LOAD, 32767, 1'b0);
        send_item(KIND_LOAD, 5, 1'b0);
        send_item(KIND_LOAD, 5, 1'b1);
        send_item(KIND_TOGGLE, 5, 1'b0);
        send_item(KIND_TOGGLE, 7, 1'b1);
        send_item(KIND_LOAD, -1, 1'b0);
        send_item(KIND_LOAD, 32767, 1'b0);
        send_item(KIND_LOAD, 3, 1'b0);
        send_item(KIND_LOAD, 100, 1'b0);       // full, dropped silently
        send_item(KIND_LOAD, 9, 1'b1);         // full, run reports rejected
        send_item(KIND_TOGGLE, 11, 1'b0);      // insert into full table
        send_item(KIND_TOGGLE, -32768, 1'b0);
        send_item(KIND_LOAD, 4, 1'b1);
        while (sb.cnt > 0) send_item(KIND_TOGGLE, sb.tbl[0], 1'b0);
        send_item(KIND_TOGGLE, 0, 1'b1);
        drain_results();

        for (int ph = 0; ph < 4; ph++) begin
            src_idle_pct   = src_mix[ph];
            sink_stall_pct = sink_mix[ph];
            for (int i = 0; i < RAND_ITEMS; i++) begin
                send_random_item();
                if (i == RAND_ITEMS / 2) drain_results();
            end
            drain_results();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (20) @(posedge aclk);

        $display("Sent %0d items and checked %0d table entries across four idle/stall mixes.",
                 sb.items_seen, sb.results_seen);
        $display("Runs by action: loaded %0d, deleted %0d, inserted %0d, rejected %0d; %0d empty.",
                 sb.action_runs[ACT_LOADED], sb.action_runs[ACT_DELETED],
                 sb.action_runs[ACT_INSERTED], sb.action_runs[ACT_REJECTED], sb.empty_runs);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

[sorted_set_toggle_table_core.f]
sv/sst_pkg.sv
sv/sst_cell.sv
sv/sorted_set_toggle_table_core.sv
tb/sorted_set_toggle_table_core_tb.sv
